>>> src/anagram_histogram_check_macros.svh
// Assertion macros for the anagram histogram check.
// Included by the checker; no other dependencies.
`ifndef ANAGRAM_HISTOGRAM_CHECK_MACROS_SVH
`define ANAGRAM_HISTOGRAM_CHECK_MACROS_SVH

// Implication checked out of reset.
`define AHC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked out of reset.
`define AHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define AHC_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ahc_pkg.sv
// Shared types and constants for the anagram histogram check.
// No dependencies; used by ahc_table and anagram_histogram_check.
`timescale 1ns / 1ps
`default_nettype none

package ahc_pkg;

  localparam int MAX_LEN  = 65535;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int DIFF_W   = LEN_W + 1;
  localparam int BYTE_W   = 8;
  localparam int NZ_W     = BYTE_W + 1;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 8;

  // One table update, sent from the issue logic to the table
  typedef struct packed {
    logic              vld;
    logic              en;
    logic [BYTE_W-1:0] addr;
    logic              dec;
    logic              final_op;
    logic              len_eq;
    logic              ovf;
  } op_t;

  // Result of one pair of words
  typedef struct packed {
    logic vld;
    logic is_anagram;
    logic overflow;
  } res_t;

endpackage

`default_nettype wire

>>> src/ahc_table.sv
// Difference table: 256-entry memory with read-modify-write, forwarding,
// per-entry valid bits and a running count of nonzero entries.
// Depends on ahc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ahc_table (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  ahc_pkg::op_t    op_in,
  output ahc_pkg::res_t   res_out
);

  localparam int DEPTH = 1 << ahc_pkg::BYTE_W;

  logic signed [ahc_pkg::DIFF_W-1:0] mem [DEPTH];
  logic signed [ahc_pkg::DIFF_W-1:0] rd_data_r;
  logic [DEPTH-1:0]                  valid_r, valid_nxt;
  ahc_pkg::op_t                      s2_r, s2_nxt;
  logic                              fwd_vld_r, fwd_vld_nxt;
  logic [ahc_pkg::BYTE_W-1:0]        fwd_addr_r;
  logic signed [ahc_pkg::DIFF_W-1:0] fwd_val_r;
  logic [ahc_pkg::NZ_W-1:0]          nz_r, nz_nxt, nz_after;
  logic signed [ahc_pkg::DIFF_W-1:0] old_val, new_val;
  logic                              do_wr;

  // Read port: address comes straight from the issue stage
  always_ff @(posedge clk) begin
    rd_data_r <= mem[op_in.addr];
  end

  // Write port
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[s2_r.addr] <= new_val;
    end
  end

  // Modify stage
  always_comb begin
    s2_nxt = op_in;
    if (s2_r.vld && fwd_vld_r && (fwd_addr_r == s2_r.addr)) begin
      old_val = fwd_val_r;
    end else if (valid_r[s2_r.addr]) begin
      old_val = rd_data_r;
    end else begin
      old_val = '0;
    end
    new_val = s2_r.dec ? (old_val - ahc_pkg::DIFF_W'(1)) : (old_val + ahc_pkg::DIFF_W'(1));
    do_wr   = s2_r.vld && s2_r.en;

    // Track how many entries are nonzero
    nz_after = nz_r;
    if (do_wr) begin
      if ((old_val == '0) && (new_val != '0)) begin
        nz_after = nz_r + ahc_pkg::NZ_W'(1);
      end else if ((old_val != '0) && (new_val == '0)) begin
        nz_after = nz_r - ahc_pkg::NZ_W'(1);
      end
    end

    // Clear the whole table after the final update of a pair
    valid_nxt   = valid_r;
    nz_nxt      = nz_after;
    fwd_vld_nxt = do_wr;
    if (s2_r.vld && s2_r.final_op) begin
      valid_nxt   = '0;
      nz_nxt      = '0;
      fwd_vld_nxt = 1'b0;
    end else if (do_wr) begin
      valid_nxt[s2_r.addr] = 1'b1;
    end

    res_out.vld        = s2_r.vld && s2_r.final_op;
    res_out.is_anagram = (nz_after == '0) && s2_r.len_eq && !s2_r.ovf;
    res_out.overflow   = s2_r.ovf;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r      <= '0;
      valid_r   <= '0;
      nz_r      <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      s2_r      <= s2_nxt;
      valid_r   <= valid_nxt;
      nz_r      <= nz_nxt;
      fwd_vld_r <= fwd_vld_nxt;
    end
  end

  // Forwarding payload
  always_ff @(posedge clk) begin
    fwd_addr_r <= s2_r.addr;
    fwd_val_r  <= new_val;
  end

endmodule

`default_nettype wire

>>> src/anagram_histogram_check.sv
// Top level of the anagram histogram check: input handshake, length
// bookkeeping, update issue and a two-entry result queue.
// Depends on ahc_pkg and ahc_table.
//
// Channel  Direction  tdata fields (low bit first)                    Side bits
// in_      slave      has_a[0] byte_a[8:1] has_b[9] byte_b[17:10]     tlast=last
// out_     master     is_anagram[0] overflow[1]                       none
//
// Each item's two table updates share the single read-modify-write path of
// the difference memory (one update a cycle), so no new item is accepted
// until the second one has issued. A result is queued after its final update.
// Synchronous active-low reset clears all counts and the valid bits; the
// table needs no clearing pass. Up to two results may wait on a stalled
// output before input acceptance stops.
`timescale 1ns / 1ps
`default_nettype none

module anagram_histogram_check (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [ahc_pkg::IN_W-1:0] in_tdata,   // has_a, byte_a, has_b, byte_b
  input  wire logic                     in_tlast,   // last
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [ahc_pkg::OUT_W-1:0]     out_tdata   // is_anagram, overflow
);

  localparam logic [ahc_pkg::LEN_W-1:0] MaxLen = ahc_pkg::LEN_W'(ahc_pkg::MAX_LEN);

  logic                       has_a, has_b, accept, pop;
  logic [ahc_pkg::BYTE_W-1:0] byte_a, byte_b;
  logic                       phase_r, phase_nxt;
  logic [ahc_pkg::LEN_W-1:0]  len_a_r, len_a_nxt, len_b_r, len_b_nxt;
  logic                       ovf_r, ovf_nxt, hit, cnt_a, cnt_b;
  logic                       len_eq, res_ovf;
  logic [1:0]                 credit_r, credit_nxt;
  ahc_pkg::op_t               op, hold_r;
  ahc_pkg::res_t              res;
  logic [1:0]                 q0_r, q1_r, push_val;
  logic [1:0]                 qcnt_r, qcnt_nxt;

  assign has_a  = in_tdata[0];
  assign byte_a = in_tdata[8:1];
  assign has_b  = in_tdata[9];
  assign byte_b = in_tdata[17:10];

  assign in_tready = rst_n && !phase_r && (credit_r < 2'd2);
  assign accept    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  // Length check and bookkeeping at acceptance
  always_comb begin
    hit   = !ovf_r && ((has_a && (len_a_r >= MaxLen)) || (has_b && (len_b_r >= MaxLen)));
    cnt_a = has_a && !ovf_r && !hit;
    cnt_b = has_b && !ovf_r && !hit;
    ovf_nxt   = ovf_r || hit;
    len_a_nxt = cnt_a ? (len_a_r + ahc_pkg::LEN_W'(1)) : len_a_r;
    len_b_nxt = cnt_b ? (len_b_r + ahc_pkg::LEN_W'(1)) : len_b_r;
    len_eq    = (len_a_nxt == len_b_nxt);
    res_ovf   = ovf_nxt;
    if (in_tlast) begin
      ovf_nxt   = 1'b0;
      len_a_nxt = '0;
      len_b_nxt = '0;
    end
  end

  // Issue the first-word update on accept, the second one in the next cycle
  always_comb begin
    op        = hold_r;
    phase_nxt = 1'b0;
    if (phase_r) begin
      op.vld = 1'b1;
    end else begin
      op.vld      = accept;
      op.en       = cnt_a;
      op.addr     = byte_a;
      op.dec      = 1'b0;
      op.final_op = 1'b0;
      op.len_eq   = len_eq;
      op.ovf      = res_ovf;
      phase_nxt   = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.vld      <= 1'b1;
      hold_r.en       <= cnt_b;
      hold_r.addr     <= byte_b;
      hold_r.dec      <= 1'b1;
      hold_r.final_op <= in_tlast;
      hold_r.len_eq   <= len_eq;
      hold_r.ovf      <= res_ovf;
    end
  end

  ahc_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_in   (op),
    .res_out (res)
  );

  // Credit covers results in flight plus results queued
  always_comb begin
    credit_nxt = credit_r;
    if (accept && in_tlast && !pop) begin
      credit_nxt = credit_r + 2'd1;
    end else if (pop && !(accept && in_tlast)) begin
      credit_nxt = credit_r - 2'd1;
    end
  end

  // Result queue
  assign push_val = {res.overflow, res.is_anagram};
  always_comb begin
    qcnt_nxt = qcnt_r;
    if (res.vld && !pop) begin
      qcnt_nxt = qcnt_r + 2'd1;
    end else if (pop && !res.vld) begin
      qcnt_nxt = qcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0_r <= q1_r;
      if (res.vld && (qcnt_r == 2'd1)) begin
        q0_r <= push_val;
      end else if (res.vld) begin
        q1_r <= push_val;
      end
    end else if (res.vld) begin
      if (qcnt_r == 2'd0) begin
        q0_r <= push_val;
      end else begin
        q1_r <= push_val;
      end
    end
  end

  assign out_tvalid = (qcnt_r != 2'd0);
  assign out_tdata  = {{(ahc_pkg::OUT_W - 2){1'b0}}, q0_r};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      len_a_r  <= '0;
      len_b_r  <= '0;
      ovf_r    <= 1'b0;
      credit_r <= '0;
      qcnt_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      credit_r <= credit_nxt;
      qcnt_r   <= qcnt_nxt;
      if (accept) begin
        len_a_r <= len_a_nxt;
        len_b_r <= len_b_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/ahc_checker.sv
// Port-level checker for the anagram histogram check, bound to the top level.
// Depends on anagram_histogram_check_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "anagram_histogram_check_macros.svh"

module ahc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // No result right after reset
  `AHC_ASSERT_NEXT_RST(a_rst_idle, !rst_n, !out_tvalid, "result valid after reset")
  // A stalled result holds
  `AHC_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  // Overflow never reports an anagram
  `AHC_ASSERT_IMPL(a_ovf, out_tvalid && out_tdata[1], !out_tdata[0], "anagram flagged with overflow")
  // No transaction is accepted in the cycle right after another
  `AHC_ASSERT_NEXT(a_rate, in_tvalid && in_tready, !in_tready, "input taken in consecutive cycles")

endmodule

bind anagram_histogram_check ahc_checker u_ahc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> verif/tb_anagram_histogram_check.sv
// Self-checking testbench for anagram_histogram_check: streams word pairs and compares
// each verdict with a byte-histogram prediction kept in the bench.
// Depends on ahc_pkg and the anagram_histogram_check RTL.
`timescale 1ns / 1ps

module tb_anagram_histogram_check;

  localparam int BYTE_VALUES    = 1 << ahc_pkg::BYTE_W;
  localparam int WATCHDOG_LIMIT = 5000;

  // Verdict fields inside out_tdata
  localparam int OUT_ANAGRAM_BIT  = 0;
  localparam int OUT_OVERFLOW_BIT = 1;

  typedef struct {
    bit is_anagram;
    bit overflow;
  } verdict_t;

  // How the second word of a random pair relates to the first
  typedef enum {
    PAIR_ANAGRAM,
    PAIR_SWAP_BYTE,
    PAIR_DROP_BYTE,
    PAIR_ADD_BYTE,
    PAIR_UNRELATED
  } pair_kind_t;

  // Which byte values a random word draws from
  typedef enum {
    ALPHA_NARROW,
    ALPHA_FULL,
    ALPHA_EXTREME
  } alphabet_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [ahc_pkg::IN_W-1:0]     in_tdata = '0;   // has_a, byte_a, has_b, byte_b
  logic                         in_tlast = 1'b0; // last
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [ahc_pkg::OUT_W-1:0]    out_tdata;       // is_anagram, overflow

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  verdict_t verdict_q[$];
  verdict_t head_verdict;

  // Predicted histogram state
  logic signed [ahc_pkg::DIFF_W-1:0] tally [BYTE_VALUES];
  logic signed [ahc_pkg::DIFF_W-1:0] len_gap;
  logic [ahc_pkg::NZ_W-1:0]          nz_count;
  logic [ahc_pkg::LEN_W-1:0]         len_a_seen;
  bit                                word_ovf;

  anagram_histogram_check u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Clear the predicted histogram, as the block does after each verdict
  function automatic void reset_histogram();
    for (int i = 0; i < BYTE_VALUES; i++) begin
      tally[i] = '0;
    end
    len_gap    = '0;
    nz_count   = '0;
    len_a_seen = '0;
    word_ovf   = 1'b0;
  endfunction

  // Move one histogram entry and track how many entries are nonzero
  function automatic void bump_tally(input logic [7:0] idx, input bit down);
    logic signed [ahc_pkg::DIFF_W-1:0] prior;
    prior = tally[idx];
    tally[idx] = down ? prior - ahc_pkg::DIFF_W'(1) : prior + ahc_pkg::DIFF_W'(1);
    if (prior == 0 && tally[idx] != 0) begin
      nz_count = nz_count + 1'b1;
    end else if (prior != 0 && tally[idx] == 0) begin
      nz_count = nz_count - 1'b1;
    end
  endfunction

  // Fold one accepted transaction into the histogram; queue a verdict on last
  function automatic void fold_item(input bit ha, input logic [7:0] ba,
                                    input bit hb, input logic [7:0] bb, input bit lst);
    int       len_a;
    int       len_b;
    verdict_t v;
    if (!word_ovf && (ha || hb)) begin
      len_a = len_a_seen;
      len_b = len_a - len_gap;
      if ((ha && len_a >= ahc_pkg::MAX_LEN) || (hb && len_b >= ahc_pkg::MAX_LEN)) begin
        word_ovf = 1'b1;
      end else begin
        if (ha) begin
          bump_tally(ba, 1'b0);
          len_a_seen = len_a_seen + 1'b1;
          len_gap    = len_gap + ahc_pkg::DIFF_W'(1);
        end
        if (hb) begin
          bump_tally(bb, 1'b1);
          len_gap = len_gap - ahc_pkg::DIFF_W'(1);
        end
      end
    end
    if (lst) begin
      v.is_anagram = !word_ovf && len_gap == 0 && nz_count == 0;
      v.overflow   = word_ovf;
      verdict_q.push_back(v);
      reset_histogram();
    end
  endfunction

  // Drive one transaction, wait for the handshake, then predict it
  task automatic send_item(input bit ha, input logic [7:0] ba,
                           input bit hb, input logic [7:0] bb, input bit lst);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, bb, hb, ba, ha};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_item(ha, ba, hb, bb, lst);
  endtask

  // Check each verdict against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected verdict: expected none, actual is_anagram=%0b overflow=%0b",
                 $time, out_tdata[OUT_ANAGRAM_BIT], out_tdata[OUT_OVERFLOW_BIT]);
      end else begin
        head_verdict = verdict_q.pop_front();
        if (out_tdata[OUT_ANAGRAM_BIT] !== head_verdict.is_anagram) begin
          mismatches++;
          $display("%0t: is_anagram mismatch: expected %0b, actual %0b",
                   $time, head_verdict.is_anagram, out_tdata[OUT_ANAGRAM_BIT]);
        end
        if (out_tdata[OUT_OVERFLOW_BIT] !== head_verdict.overflow) begin
          mismatches++;
          $display("%0t: overflow mismatch: expected %0b, actual %0b",
                   $time, head_verdict.overflow, out_tdata[OUT_OVERFLOW_BIT]);
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte(input alphabet_t alpha, input logic [7:0] base);
    logic [7:0] extremes [6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
    case (alpha)
      ALPHA_NARROW:  return base + 8'($urandom_range(3));
      ALPHA_FULL:    return 8'($urandom_range(255));
      default:       return extremes[$urandom_range(5)];
    endcase
  endfunction

  // Empty words, cancelling bytes, length mismatch and ignored bytes
  task automatic test_special_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(1'b0, 8'h00, 1'b0, 8'h00, 1'b1);
    send_item(1'b1, 8'h00, 1'b1, 8'h00, 1'b1);
    send_item(1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_item(1'b1, 8'hFF, 1'b0, 8'h00, 1'b1);
    send_item(1'b0, 8'h00, 1'b1, 8'h80, 1'b1);
    send_item(1'b1, 8'h12, 1'b1, 8'h34, 1'b0);
    send_item(1'b1, 8'h34, 1'b1, 8'h12, 1'b1);
    send_item(1'b1, 8'hAA, 1'b1, 8'h55, 1'b1);
    send_item(1'b0, 8'hFF, 1'b0, 8'hFF, 1'b1);
    send_item(1'b1, 8'h01, 1'b0, 8'hFF, 1'b0);
    send_item(1'b1, 8'h01, 1'b0, 8'hFF, 1'b0);
    send_item(1'b0, 8'hFF, 1'b1, 8'h01, 1'b0);
    send_item(1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'hFF, 1'b1, 8'h01, 1'b1);
    send_item(1'b1, 8'h7F, 1'b1, 8'h80, 1'b0);
    send_item(1'b1, 8'h80, 1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'h00, 1'b1, 8'h7F, 1'b1);
  endtask

  // Random word pairs, mostly anagrams with small edits, fed at random interleave
  task automatic test_random_pairs(input int n_items, input int sender_idle,
                                   input int recv_stall);
    logic [7:0] word_a[$];
    logic [7:0] word_b[$];
    logic [7:0] tmp;
    logic [7:0] base;
    logic [7:0] ba;
    logic [7:0] bb;
    alphabet_t  alpha;
    pair_kind_t kind;
    int         sent;
    int         len;
    int         roll;
    int         k;
    int         ia;
    int         ib;
    bit         ha;
    bit         hb;
    bit         lst;
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    sent = 0;
    while (sent < n_items) begin
      // Build the first word
      alpha = alphabet_t'($urandom_range(2));
      base  = 8'($urandom_range(255));
      len   = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(8);
      word_a.delete();
      for (int j = 0; j < len; j++) word_a.push_back(pick_byte(alpha, base));

      // Derive the second word: shuffle, then maybe edit
      roll = $urandom_range(9);
      kind = (roll < 6) ? PAIR_ANAGRAM : pair_kind_t'(roll - 5);
      word_b = word_a;
      for (int j = word_b.size() - 1; j > 0; j--) begin
        k = $urandom_range(j);
        tmp = word_b[j];
        word_b[j] = word_b[k];
        word_b[k] = tmp;
      end
      case (kind)
        PAIR_SWAP_BYTE:
          if (word_b.size() > 0) word_b[$urandom_range(word_b.size() - 1)] = pick_byte(alpha, base);
        PAIR_DROP_BYTE:
          if (word_b.size() > 0) word_b.delete($urandom_range(word_b.size() - 1));
        PAIR_ADD_BYTE:
          word_b.insert($urandom_range(word_b.size()), pick_byte(alpha, base));
        PAIR_UNRELATED: begin
          word_b.delete();
          len = $urandom_range(8);
          for (int j = 0; j < len; j++) word_b.push_back(pick_byte(alpha, base));
        end
        default: ;
      endcase

      // Stream both words with random interleave; last may ride on the final bytes
      ia  = 0;
      ib  = 0;
      lst = 1'b0;
      while (!lst) begin
        ha = ia < word_a.size() && $urandom_range(3) != 0;
        hb = ib < word_b.size() && $urandom_range(3) != 0;
        ba = ha ? word_a[ia] : 8'($urandom_range(255));
        bb = hb ? word_b[ib] : 8'($urandom_range(255));
        if (ha) ia++;
        if (hb) ib++;
        lst = ia == word_a.size() && ib == word_b.size() && $urandom_range(3) != 0;
        send_item(ha, ba, hb, bb, lst);
        if (ha || hb || lst) sent++;
      end
    end
  endtask

  initial begin
    reset_histogram();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_random_pairs(350, 0, 0);
    test_random_pairs(350, 66, 0);
    test_random_pairs(350, 0, 66);
    test_random_pairs(350, 12, 12);
    in_tvalid <= 1'b0;

    // Drain outstanding verdicts, then allow for the result latency
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
